@@ hdl/pkf_pkg.sv @@
// Shared types, constants and helpers for the pseudo-Kleinian fold step.
package pkf_pkg;

   localparam int FRAC_BITS = 20;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [30:0] KCAP = 31'h7FFF_FFFF;

   localparam logic [30:0] BOX_RESET = 31'd734003;
   localparam logic [30:0] MIN_RADIUS_RESET = 31'd524288;
   localparam logic [31:0] DE_TWEAK_RESET = 32'd52429;
   localparam logic [1:0] FOLD_MODE_RESET = 2'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_SIZE_X = 3'd0,
      CSR_BOX_SIZE_Y = 3'd1,
      CSR_BOX_SIZE_Z = 3'd2,
      CSR_MIN_RADIUS = 3'd3,
      CSR_DE_TWEAK   = 3'd4,
      CSR_FOLD_MODE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        deriv;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
      logic [31:0]        new_deriv;
      logic               saturated;
   } rsp_type;

   // Point in flight: three coordinates, derivative and sticky clip flag.
   typedef struct packed {
      logic [2:0][31:0] z;
      logic [31:0]      de;
      logic             sat;
   } point_type;

   // Clip a signed value to 32 bits; result is {clipped, value}.
   function automatic logic [32:0] clip_s32(input logic signed [63:0] v);
      logic [32:0] r;
      if (v > 64'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -64'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

@@ hdl/pseudo_kleinian_fold_step.sv @@
// Top level of the pseudo-Kleinian fold step: folds, two inversion pipelines, result register.
//
// One item in, one result out. req_valid/req_ready move a point (pos_x, pos_y, pos_z) and
// its derivative; rsp_valid/rsp_ready move the folded, scaled point, the new derivative and
// a saturated flag. The csr_ port writes box sizes, min radius, derivative tweak and fold
// mode at any edge with csr_we high; indexes past the last register are dropped.
// Each of the two fold passes has one fold stage and a 37-stage inversion; a result register
// follows. Each inversion holds a 32-stage restoring divider: a first stage checks for a
// capped quotient, then one quotient bit per stage. Throughput is one item per unstalled cycle.
// Passes not selected by fold_mode flow through their stages unchanged.
// Reset empties the pipeline and loads the register defaults.
// When the receiver holds rsp_ready low with a result waiting, the whole pipeline freezes
// and req_ready drops; nothing in flight is lost or repeated, and empty slots fill as
// long as the result register is free.
module pseudo_kleinian_fold_step_unit #(
   parameter int FRAC_BITS = pkf_pkg::FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pkf_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pkf_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [pkf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pkf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [2:0][30:0] box_ff;
   logic [30:0]      min_radius_ff;
   logic [31:0]      de_tweak_ff;
   logic [1:0]       fold_mode_ff;

   logic               adv;
   logic               f1_v_ff, f1_act_ff, f2_v_ff, f2_act_ff;
   pkf_pkg::point_type f1_pt_ff, f2_pt_ff;
   pkf_pkg::point_type f1_pt_in, f2_pt_in;
   logic               i1_v, i2_v;
   pkf_pkg::point_type i1_pt, i2_pt;
   logic               rsp_valid_ff;
   pkf_pkg::rsp_type   rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff        <= {3{pkf_pkg::BOX_RESET}};
         min_radius_ff <= pkf_pkg::MIN_RADIUS_RESET;
         de_tweak_ff   <= pkf_pkg::DE_TWEAK_RESET;
         fold_mode_ff  <= pkf_pkg::FOLD_MODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pkf_pkg::CSR_BOX_SIZE_X: box_ff[0]     <= csr_wdata[30:0];
            pkf_pkg::CSR_BOX_SIZE_Y: box_ff[1]     <= csr_wdata[30:0];
            pkf_pkg::CSR_BOX_SIZE_Z: box_ff[2]     <= csr_wdata[30:0];
            pkf_pkg::CSR_MIN_RADIUS: min_radius_ff <= csr_wdata[30:0];
            pkf_pkg::CSR_DE_TWEAK:   de_tweak_ff   <= csr_wdata;
            pkf_pkg::CSR_FOLD_MODE:  fold_mode_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // clamp-reflect: 2*clamp(z) - z
   always_comb begin
      logic signed [34:0] zs, bs, t, v;
      logic [32:0]        c;
      zs = '0;
      bs = '0;
      t  = '0;
      v  = '0;
      c  = '0;
      f1_pt_in.z[0] = req_data.pos_x;
      f1_pt_in.z[1] = req_data.pos_y;
      f1_pt_in.z[2] = req_data.pos_z;
      f1_pt_in.de   = req_data.deriv;
      f1_pt_in.sat  = 1'b0;
      if (fold_mode_ff[0]) begin
         for (int i = 0; i < 3; i++) begin
            zs = 35'($signed(f1_pt_in.z[i]));
            bs = $signed({4'd0, box_ff[i]});
            if (zs > bs) begin
               t = bs;
            end else if (zs < -bs) begin
               t = -bs;
            end else begin
               t = zs;
            end
            v = (t <<< 1) - zs;
            c = pkf_pkg::clip_s32(64'(v));
            f1_pt_in.z[i] = c[31:0];
            f1_pt_in.sat  = f1_pt_in.sat | c[32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (adv) begin
         f1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_pt_ff  <= f1_pt_in;
         f1_act_ff <= fold_mode_ff[0];
      end
   end

   pkf_invert #(.FRAC_BITS(FRAC_BITS)) u_inv1 (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (f1_v_ff),
      .in_active  (f1_act_ff),
      .in_pt      (f1_pt_ff),
      .min_radius (min_radius_ff),
      .de_tweak   (de_tweak_ff),
      .out_valid  (i1_v),
      .out_pt     (i1_pt)
   );

   // conditional reflect, upper side first
   always_comb begin
      logic signed [34:0] v, bs;
      logic [32:0]        c;
      v  = '0;
      bs = '0;
      c  = '0;
      f2_pt_in = i1_pt;
      if (fold_mode_ff[1]) begin
         for (int i = 0; i < 3; i++) begin
            v  = 35'($signed(i1_pt.z[i]));
            bs = $signed({4'd0, box_ff[i]});
            if (v > bs) begin
               v = (bs <<< 1) - v;
            end
            if (v < -bs) begin
               v = -(bs <<< 1) - v;
            end
            c = pkf_pkg::clip_s32(64'(v));
            f2_pt_in.z[i] = c[31:0];
            f2_pt_in.sat  = f2_pt_in.sat | c[32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_v_ff <= 1'b0;
      end else if (adv) begin
         f2_v_ff <= i1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_pt_ff  <= f2_pt_in;
         f2_act_ff <= fold_mode_ff[1];
      end
   end

   pkf_invert #(.FRAC_BITS(FRAC_BITS)) u_inv2 (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (f2_v_ff),
      .in_active  (f2_act_ff),
      .in_pt      (f2_pt_ff),
      .min_radius (min_radius_ff),
      .de_tweak   (de_tweak_ff),
      .out_valid  (i2_v),
      .out_pt     (i2_pt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= i2_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.new_x     <= i2_pt.z[0];
         rsp_ff.new_y     <= i2_pt.z[1];
         rsp_ff.new_z     <= i2_pt.z[2];
         rsp_ff.new_deriv <= i2_pt.de;
         rsp_ff.saturated <= i2_pt.sat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while result stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_pass_fold1: assert property (@(posedge clock) disable iff (reset)
      (adv && !fold_mode_ff[0]) |=>
         (f1_pt_ff.z[0] == $past(req_data.pos_x)) && (f1_pt_ff.de == $past(req_data.deriv))
         && !f1_pt_ff.sat)
      else $error("first fold altered point while disabled");

endmodule

@@ hdl/pkf_invert.sv @@
// Pipelined sphere inversion: |z|^2, restoring divide one bit per stage, scale point and deriv.
module pkf_invert #(
   parameter int FRAC_BITS = pkf_pkg::FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic                in_active,
   input  pkf_pkg::point_type  in_pt,
   input  logic [30:0]         min_radius,
   input  logic [31:0]         de_tweak,
   output logic                out_valid,
   output pkf_pkg::point_type  out_pt
);

   localparam int R2W = 64 - FRAC_BITS;
   localparam int NW  = 31 + FRAC_BITS;
   localparam int CW  = R2W + 31;
   localparam int QB  = 31;
   localparam logic [30:0] ONEQ = 31'(1) << FRAC_BITS;

   // square stage
   logic               s0_v_ff, s0_act_ff;
   pkf_pkg::point_type s0_pt_ff;
   logic [2:0][63:0]   s0_sq_ff;
   // sum stage
   logic               s1_v_ff, s1_act_ff;
   pkf_pkg::point_type s1_pt_ff;
   logic [R2W-1:0]     s1_r2_ff;
   // divider stages
   logic               dv_ff  [0:QB];
   logic               dact_ff[0:QB];
   pkf_pkg::point_type dpt_ff [0:QB];
   logic [R2W-1:0]     dr2_ff [0:QB];
   logic [NW-1:0]      rem_ff [0:QB];
   logic [QB-1:0]      q_ff   [0:QB];
   logic               cap_ff [0:QB];
   // k stage
   logic               sk_v_ff, sk_act_ff;
   pkf_pkg::point_type sk_pt_ff;
   logic [30:0]        sk_k_ff;
   // multiply stage
   logic               sm_v_ff, sm_act_ff;
   pkf_pkg::point_type sm_pt_ff;
   logic [2:0][63:0]   sm_pm_ff;
   logic [63:0]        sm_dm_ff;
   logic               sm_gneg_ff;
   // output stage
   logic               so_v_ff;
   pkf_pkg::point_type so_pt_ff;

   logic [2:0][31:0]   abs_in;
   logic [63:0]        sum_in;
   logic [30:0]        k_in;
   logic signed [32:0] g_in;
   logic [2:0][63:0]   pm_in;
   pkf_pkg::point_type so_pt_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_in[i] = in_pt.z[i][31] ? (32'd0 - in_pt.z[i]) : in_pt.z[i];
      end
      sum_in = s0_sq_ff[0] + s0_sq_ff[1] + s0_sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= in_valid;
         s1_v_ff <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_act_ff <= in_active;
         s0_pt_ff  <= in_pt;
         for (int i = 0; i < 3; i++) begin
            s0_sq_ff[i] <= 64'(abs_in[i]) * 64'(abs_in[i]);
         end
         s1_act_ff <= s0_act_ff;
         s1_pt_ff  <= s0_pt_ff;
         s1_r2_ff  <= sum_in[63:FRAC_BITS];
      end
   end

   genvar j;
   generate
      for (j = 0; j <= QB; j++) begin : g_div
         logic [CW-1:0] trial;
         logic          hit;
         logic [NW-1:0] rem_in;
         logic [QB-1:0] q_in;
         logic          v_prev, act_prev;
         pkf_pkg::point_type pt_prev;
         logic [R2W-1:0] r2_prev;
         logic           cap_prev;

         if (j == 0) begin : g_first
            logic [NW-1:0] num;
            always_comb begin
               num      = {min_radius, {FRAC_BITS{1'b0}}};
               trial    = {s1_r2_ff, 31'd0};
               // quotient of 2^31 or more, or zero radius: cap k
               hit      = trial <= CW'(num);
               rem_in   = num;
               q_in     = '0;
               v_prev   = s1_v_ff;
               act_prev = s1_act_ff;
               pt_prev  = s1_pt_ff;
               r2_prev  = s1_r2_ff;
               cap_prev = hit;
            end
         end else begin : g_step
            always_comb begin
               trial    = CW'(dr2_ff[j-1]) << (QB - j);
               hit      = trial <= CW'(rem_ff[j-1]);
               rem_in   = hit ? (rem_ff[j-1] - trial[NW-1:0]) : rem_ff[j-1];
               q_in     = q_ff[j-1] | (QB'(hit) << (QB - j));
               v_prev   = dv_ff[j-1];
               act_prev = dact_ff[j-1];
               pt_prev  = dpt_ff[j-1];
               r2_prev  = dr2_ff[j-1];
               cap_prev = cap_ff[j-1];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[j] <= 1'b0;
            end else if (adv) begin
               dv_ff[j] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               dact_ff[j] <= act_prev;
               dpt_ff[j]  <= pt_prev;
               dr2_ff[j]  <= r2_prev;
               rem_ff[j]  <= rem_in;
               q_ff[j]    <= q_in;
               cap_ff[j]  <= cap_prev;
            end
         end
      end
   endgenerate

   always_comb begin
      if (cap_ff[QB]) begin
         k_in = pkf_pkg::KCAP;
      end else if (q_ff[QB] < ONEQ) begin
         k_in = ONEQ;
      end else begin
         k_in = q_ff[QB];
      end
      g_in = $signed({2'b00, sk_k_ff}) + $signed({de_tweak[31], de_tweak});
      for (int i = 0; i < 3; i++) begin
         pm_in[i] = 64'($signed(sk_pt_ff.z[i]) * $signed({1'b0, sk_k_ff}));
      end
   end

   always_comb begin
      logic signed [63:0] sh;
      logic [63:0]        dsh;
      logic [32:0]        c;
      sh       = '0;
      dsh      = '0;
      c        = '0;
      so_pt_in = sm_pt_ff;
      if (sm_act_ff) begin
         for (int i = 0; i < 3; i++) begin
            sh = $signed(sm_pm_ff[i]) >>> FRAC_BITS;
            c  = pkf_pkg::clip_s32(sh);
            so_pt_in.z[i] = c[31:0];
            so_pt_in.sat  = so_pt_in.sat | c[32];
         end
         dsh = sm_dm_ff >> FRAC_BITS;
         if (sm_gneg_ff) begin
            so_pt_in.de  = '0;
            so_pt_in.sat = so_pt_in.sat | (sm_pt_ff.de != 32'd0);
         end else if (dsh[63:32] != 32'd0) begin
            so_pt_in.de  = 32'hFFFF_FFFF;
            so_pt_in.sat = 1'b1;
         end else begin
            so_pt_in.de = dsh[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sk_v_ff <= 1'b0;
         sm_v_ff <= 1'b0;
         so_v_ff <= 1'b0;
      end else if (adv) begin
         sk_v_ff <= dv_ff[QB];
         sm_v_ff <= sk_v_ff;
         so_v_ff <= sm_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sk_act_ff  <= dact_ff[QB];
         sk_pt_ff   <= dpt_ff[QB];
         sk_k_ff    <= k_in;
         sm_act_ff  <= sk_act_ff;
         sm_pt_ff   <= sk_pt_ff;
         sm_pm_ff   <= pm_in;
         sm_dm_ff   <= 64'(sk_pt_ff.de) * 64'(g_in[31:0]);
         sm_gneg_ff <= g_in[32];
         so_pt_ff   <= so_pt_in;
      end
   end

   assign out_valid = so_v_ff;
   assign out_pt    = so_pt_ff;

endmodule
